// File: rtl/prrt_pkg.sv
// shared types and codes for the partition replica route table
// request and result item structs, request and status codes, default sizes
// no dependencies
package prrt_pkg;

    localparam int DEF_NAMESPACES     = 4;
    localparam int DEF_MAX_PARTITIONS = 4096;
    localparam int DEF_REPLICAS       = 3;
    localparam int DEF_NODE_BITS      = 8;

    // partition count register
    localparam int            PC_W     = 13;
    localparam logic [PC_W-1:0] PC_RESET = 13'd4096;

    // request codes
    localparam logic [2:0] REQ_SET_WRITE = 3'd0;
    localparam logic [2:0] REQ_ADD_READ  = 3'd1;
    localparam logic [2:0] REQ_GET_WRITE = 3'd2;
    localparam logic [2:0] REQ_GET_READ  = 3'd3;
    localparam logic [2:0] REQ_REMOVE    = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NONE  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  namespace_index;
        logic [11:0] partition_id;
        logic [7:0]  node_id;
    } req_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] node_result;
    } res_item_t;

    // control from the entry update logic back to the sequencer
    typedef struct packed {
        logic       wr_en;
        logic       set_valid;
        logic       rr_step;
        logic [1:0] status;
    } upd_info_t;

endpackage

// File: rtl/prrt_ram.sv
// generic simple dual port ram, one write port, one registered read port
// depends on nothing
module prrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/prrt_entry_update.sv
// read-modify-write logic for one partition entry (write node, count, replica list)
// depends on prrt_pkg
module prrt_entry_update import prrt_pkg::*; #(
    parameter int REPLICAS  = DEF_REPLICAS,
    parameter int NODE_BITS = DEF_NODE_BITS,
    localparam int CNT_W   = $clog2(REPLICAS + 1),
    localparam int IDX_W   = (REPLICAS > 1) ? $clog2(REPLICAS) : 1,
    localparam int CNT_LO  = REPLICAS * NODE_BITS,
    localparam int WN_LO   = CNT_LO + CNT_W,
    localparam int ENTRY_W = WN_LO + NODE_BITS
) (
    input  logic                      purge,
    input  logic [2:0]                req_type,
    input  logic [NODE_BITS-1:0]      node,
    input  logic                      pid_ok,
    input  logic                      ns_ok,
    input  logic                      tbl_valid,
    input  logic [ENTRY_W-1:0]        entry_old,
    input  logic [REPLICAS*IDX_W-1:0] rr_res,
    output logic [ENTRY_W-1:0]        entry_new,
    output logic [NODE_BITS-1:0]      node_out,
    output upd_info_t                 info
);

    logic [NODE_BITS-1:0] lst     [REPLICAS];
    logic [NODE_BITS-1:0] lst_up  [REPLICAS];
    logic [REPLICAS-1:0]  shifted;
    logic [NODE_BITS-1:0] wn;
    logic [NODE_BITS-1:0] pick;
    logic [CNT_W-1:0]     cnt;
    logic [CNT_W-1:0]     n_eff;
    logic [IDX_W-1:0]     pick_idx;
    logic                 present;
    logic                 found;

    always_comb
    begin
        wn  = entry_old[WN_LO +: NODE_BITS];
        cnt = entry_old[CNT_LO +: CNT_W];
        for (int j = 0; j < REPLICAS; j++)
        begin
            lst[j] = entry_old[j*NODE_BITS +: NODE_BITS];
        end
        for (int k = 0; k < REPLICAS - 1; k++)
        begin
            lst_up[k] = lst[k+1];
        end
        lst_up[REPLICAS-1] = '0;

        n_eff = (32'(cnt) > REPLICAS) ? CNT_W'(REPLICAS) : cnt;

        present = 1'b0;
        for (int j = 0; j < REPLICAS; j++)
        begin
            if (j < int'(n_eff) && lst[j] == node)
            begin
                present = 1'b1;
            end
        end

        // first match marks where the list closes up
        found = 1'b0;
        for (int j = 0; j < REPLICAS; j++)
        begin
            if (!found && j < int'(cnt) && lst[j] == node)
            begin
                found = 1'b1;
            end
            shifted[j] = found;
        end

        // round robin slot: new counter value mod list length
        pick_idx = '0;
        for (int k = 1; k <= REPLICAS; k++)
        begin
            if (int'(n_eff) == k)
            begin
                pick_idx = rr_res[(k-1)*IDX_W +: IDX_W];
            end
        end
        pick = '0;
        for (int j = 0; j < REPLICAS; j++)
        begin
            if (int'(pick_idx) == j)
            begin
                pick = lst[j];
            end
        end

        entry_new   = entry_old;
        node_out    = '0;
        info        = '0;
        info.status = STAT_OK;

        if (purge)
        begin
            info.wr_en = tbl_valid && pid_ok && ns_ok;
            if (wn == node)
            begin
                entry_new[WN_LO +: NODE_BITS] = '0;
            end
            for (int k = 0; k < REPLICAS; k++)
            begin
                if (shifted[k])
                begin
                    entry_new[k*NODE_BITS +: NODE_BITS] = lst_up[k];
                end
            end
            if (found)
            begin
                entry_new[CNT_LO +: CNT_W] = cnt - CNT_W'(1);
            end
        end
        else
        begin
            case (req_type)
                REQ_SET_WRITE, REQ_ADD_READ, REQ_GET_WRITE, REQ_GET_READ:
                begin
                    if (!pid_ok)
                    begin
                        info.status = STAT_RANGE;
                    end
                    else if (!ns_ok)
                    begin
                        info.status = STAT_NONE;
                    end
                    else if (req_type == REQ_SET_WRITE)
                    begin
                        info.set_valid = 1'b1;
                        info.wr_en     = 1'b1;
                        entry_new[WN_LO +: NODE_BITS] = node;
                    end
                    else if (req_type == REQ_ADD_READ)
                    begin
                        info.set_valid = 1'b1;
                        if (node != '0 && !present)
                        begin
                            info.wr_en = 1'b1;
                            if (32'(n_eff) >= REPLICAS)
                            begin
                                entry_new[0 +: NODE_BITS] = node;
                            end
                            else
                            begin
                                for (int j = 0; j < REPLICAS; j++)
                                begin
                                    if (j == int'(n_eff))
                                    begin
                                        entry_new[j*NODE_BITS +: NODE_BITS] = node;
                                    end
                                end
                                entry_new[CNT_LO +: CNT_W] = n_eff + CNT_W'(1);
                            end
                        end
                    end
                    else if (!tbl_valid)
                    begin
                        info.status = STAT_NONE;
                    end
                    else if (req_type == REQ_GET_WRITE)
                    begin
                        node_out    = wn;
                        info.status = (wn == '0) ? STAT_NONE : STAT_OK;
                    end
                    else if (n_eff == '0)
                    begin
                        info.status = STAT_NONE;
                    end
                    else
                    begin
                        info.rr_step = 1'b1;
                        node_out     = pick;
                        info.status  = (pick == '0) ? STAT_NONE : STAT_OK;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: rtl/partition_replica_route_table.sv
// partition replica route table: request item to result item through one ram
// read-modify-write; the result strobe is registered after the lookup state and the
// next item can be taken in the same cycle as the strobe.
// a node removal sweeps all 2^(ns bits + partition bits) entries, then writes back the last.
// after reset the entry ram is cleared, all 2^(ns bits + partition bits) entries
// (16384 by default), with busy high; configuration writes are taken meanwhile.
module partition_replica_route_table import prrt_pkg::*; #(
    parameter int NAMESPACES     = DEF_NAMESPACES,
    parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS,
    parameter int REPLICAS       = DEF_REPLICAS,
    parameter int NODE_BITS      = DEF_NODE_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  req_item_t       req,
    output logic            done,
    output res_item_t       result,
    input  logic            cfg_we,
    input  logic [PC_W-1:0] cfg_wdata
);

    localparam int NS_W    = (NAMESPACES > 1) ? $clog2(NAMESPACES) : 1;
    localparam int PART_W  = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int ADDR_W  = NS_W + PART_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int LIM_W   = $clog2(MAX_PARTITIONS + 1);
    localparam int CNT_W   = $clog2(REPLICAS + 1);
    localparam int IDX_W   = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;
    localparam int ENTRY_W = NODE_BITS * (REPLICAS + 1) + CNT_W;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_LOOK   = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_WFLUSH = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    req_item_t             req_reg;
    logic [ADDR_W-1:0]     sweep_reg, sweep_next;
    logic [ADDR_W-1:0]     prev_reg;
    logic                  pend_reg, pend_next;
    logic                  done_reg, done_next;
    res_item_t             res_out_reg;
    logic [PC_W-1:0]       pc_reg;
    logic [NAMESPACES-1:0] tv_reg, tv_next;
    logic [31:0]           rr_counter_reg;
    logic [IDX_W-1:0]      res_reg  [REPLICAS];
    logic [IDX_W-1:0]      res_next [REPLICAS];

    logic                      accept;
    logic                      purge;
    logic [ADDR_W-1:0]         in_addr;
    logic [ADDR_W-1:0]         look_addr;
    logic [LIM_W-1:0]          limit;
    logic [NODE_BITS-1:0]      node;
    logic                      look_ns_ok, look_pid_ok;
    logic [NS_W-1:0]           w_ns;
    logic [PART_W-1:0]         w_pid;
    logic                      w_ns_ok, w_pid_ok;
    logic [NS_W-1:0]           sel_ns;
    logic                      sel_tv;
    logic                      ram_we, ram_re;
    logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]        ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0]        entry_new;
    logic [NODE_BITS-1:0]      node_out;
    logic [REPLICAS*IDX_W-1:0] rr_res_flat;
    upd_info_t                 info;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign purge  = (state_reg == ST_WALK) || (state_reg == ST_WFLUSH);
    assign node   = NODE_BITS'(req_reg.node_id);

    assign in_addr   = {NS_W'(req.namespace_index), PART_W'(req.partition_id)};
    assign look_addr = {NS_W'(req_reg.namespace_index), PART_W'(req_reg.partition_id)};

    assign limit = (32'(pc_reg) > MAX_PARTITIONS) ? LIM_W'(MAX_PARTITIONS) : LIM_W'(pc_reg);

    assign look_ns_ok  = 32'(req_reg.namespace_index) < NAMESPACES;
    assign look_pid_ok = 32'(req_reg.partition_id) < 32'(limit);

    assign w_ns     = prev_reg[ADDR_W-1 -: NS_W];
    assign w_pid    = prev_reg[PART_W-1:0];
    assign w_ns_ok  = 32'(w_ns) < NAMESPACES;
    assign w_pid_ok = 32'(w_pid) < 32'(limit);

    assign sel_ns = purge ? w_ns : NS_W'(req_reg.namespace_index);

    always_comb
    begin
        sel_tv = 1'b0;
        for (int i = 0; i < NAMESPACES; i++)
        begin
            if (32'(sel_ns) == i)
            begin
                sel_tv = tv_reg[i];
            end
        end
    end

    // residues of the counter after one more step, one per list length
    always_comb
    begin
        for (int k = 0; k < REPLICAS; k++)
        begin
            if ((&rr_counter_reg) || int'(res_reg[k]) == k)
            begin
                res_next[k] = '0;
            end
            else
            begin
                res_next[k] = res_reg[k] + IDX_W'(1);
            end
            rr_res_flat[k*IDX_W +: IDX_W] = res_next[k];
        end
    end

    prrt_entry_update #(
        .REPLICAS  (REPLICAS),
        .NODE_BITS (NODE_BITS)
    ) u_update (
        .purge     (purge),
        .req_type  (req_reg.req_type),
        .node      (node),
        .pid_ok    (purge ? w_pid_ok : look_pid_ok),
        .ns_ok     (purge ? w_ns_ok : look_ns_ok),
        .tbl_valid (sel_tv),
        .entry_old (ram_rdata),
        .rr_res    (rr_res_flat),
        .entry_new (entry_new),
        .node_out  (node_out),
        .info      (info)
    );

    prrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = prev_reg;
        ram_wdata = entry_new;
        ram_re    = 1'b0;
        ram_raddr = sweep_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                ram_re    = accept;
                ram_raddr = in_addr;
            end
            ST_LOOK:
            begin
                ram_we    = info.wr_en;
                ram_waddr = look_addr;
            end
            ST_WALK:
            begin
                ram_re = 1'b1;
                ram_we = pend_reg && info.wr_en;
            end
            ST_WFLUSH:
            begin
                ram_we = pend_reg && info.wr_en;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        pend_next  = pend_reg;
        done_next  = 1'b0;
        tv_next    = tv_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                sweep_next = sweep_reg + ADDR_W'(1);
                if (&sweep_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    sweep_next = '0;
                    pend_next  = 1'b0;
                    if (req.req_type == REQ_REMOVE && NODE_BITS'(req.node_id) != '0)
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                for (int i = 0; i < NAMESPACES; i++)
                begin
                    if (info.set_valid && 32'(req_reg.namespace_index) == i)
                    begin
                        tv_next[i] = 1'b1;
                    end
                end
            end
            ST_WALK:
            begin
                pend_next  = 1'b1;
                sweep_next = sweep_reg + ADDR_W'(1);
                if (&sweep_reg)
                begin
                    state_next = ST_WFLUSH;
                end
            end
            ST_WFLUSH:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            sweep_reg      <= '0;
            pend_reg       <= 1'b0;
            done_reg       <= 1'b0;
            tv_reg         <= '0;
            pc_reg         <= PC_RESET;
            rr_counter_reg <= '0;
            for (int k = 0; k < REPLICAS; k++)
            begin
                res_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            tv_reg    <= tv_next;
            if (cfg_we)
            begin
                pc_reg <= cfg_wdata;
            end
            if (state_reg == ST_LOOK && info.rr_step)
            begin
                rr_counter_reg <= rr_counter_reg + 32'd1;
                for (int k = 0; k < REPLICAS; k++)
                begin
                    res_reg[k] <= res_next[k];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (state_reg == ST_WALK)
        begin
            prev_reg <= sweep_reg;
        end
        if (done_next)
        begin
            res_out_reg.status      <= info.status;
            res_out_reg.node_result <= 8'(node_out);
        end
    end

    assign done   = done_reg;
    assign result = res_out_reg;

    // a result only follows a lookup cycle or the end of a removal sweep
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_LOOK || $past(state_reg) == ST_WFLUSH))
        else $error("result strobe without a finished item");

    // the read-modify-write never reads and writes the same entry in one cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("entry ram read and write collide");

    // the lookup cycle always follows an accepted item
    a_look_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |-> $past(start && !busy))
        else $error("lookup without an accepted item");

    // the sweep write-back lags its read by exactly one entry
    a_walk_lag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && pend_reg) |-> (prev_reg == sweep_reg - ADDR_W'(1)))
        else $error("removal sweep write-back out of step");

endmodule

// File: tb/tb_partition_replica_route_table.sv
`timescale 1ns / 1ps
// self-checking testbench for partition_replica_route_table: queued request items,
// a bursty driver, a monitor and a route table predictor kept in step with the block
// depends on prrt_pkg and the rtl top level
module tb_partition_replica_route_table;
    import prrt_pkg::*;

    localparam int NS             = DEF_NAMESPACES;
    localparam int MAXP           = DEF_MAX_PARTITIONS;
    localparam int REPL           = DEF_REPLICAS;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_ITEMS    = 106;
    localparam int PHASES         = 8;

    // request codes the block does not define
    localparam logic [2:0] REQ_UNUSED_LO  = 3'd5;
    localparam logic [2:0] REQ_UNUSED_MID = 3'd6;
    localparam logic [2:0] REQ_UNUSED_HI  = 3'd7;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    req_item_t       req = '0;
    logic            cfg_we = 1'b0;
    logic [PC_W-1:0] cfg_wdata = '0;
    logic            busy;
    logic            done;
    res_item_t       result;

    partition_replica_route_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the table
    logic            tbl_valid [NS];
    logic [7:0]      wr_node   [NS][MAXP];
    logic [1:0]      rep_cnt   [NS][MAXP];
    logic [7:0]      rep_list  [NS][MAXP][REPL];
    logic [31:0]     rr_cnt;
    logic [PC_W-1:0] part_cnt;

    req_item_t req_backlog[$];
    res_item_t route_expect_q[$];
    int        mismatches = 0;
    int        burst_left = 1;
    int        gap_left = 0;
    int        idle_cycles = 0;

    function automatic int active_parts();
        return (part_cnt > MAXP) ? MAXP : int'(part_cnt);
    endfunction

    function automatic void purge_node(logic [7:0] node);
        int   lim;
        logic found;
        lim = active_parts();
        for (int t = 0; t < NS; t++)
        begin
            if (!tbl_valid[t])
                continue;
            for (int p = 0; p < lim; p++)
            begin
                if (wr_node[t][p] == node)
                    wr_node[t][p] = '0;
                found = 1'b0;
                for (int j = 0; j < rep_cnt[t][p] && !found; j++)
                begin
                    if (rep_list[t][p][j] == node)
                    begin
                        for (int k = j; k + 1 < REPL; k++)
                            rep_list[t][p][k] = rep_list[t][p][k + 1];
                        rep_list[t][p][REPL - 1] = '0;
                        rep_cnt[t][p] = rep_cnt[t][p] - 2'd1;
                        found = 1'b1;
                    end
                end
            end
        end
    endfunction

    function automatic res_item_t route_predict(req_item_t r);
        res_item_t   o;
        int          ns;
        int          pid;
        logic [31:0] n;
        logic        present;
        o = '0;
        ns = r.namespace_index;
        pid = r.partition_id;
        if (r.req_type == REQ_REMOVE)
        begin
            if (r.node_id != 0)
                purge_node(r.node_id);
        end
        else if (r.req_type inside {[REQ_SET_WRITE:REQ_GET_READ]})
        begin
            if (pid >= active_parts())
                o.status = STAT_RANGE;
            else if (ns >= NS)
                o.status = STAT_NONE;
            else if (r.req_type == REQ_SET_WRITE)
            begin
                tbl_valid[ns] = 1'b1;
                wr_node[ns][pid] = r.node_id;
            end
            else if (r.req_type == REQ_ADD_READ)
            begin
                tbl_valid[ns] = 1'b1;
                if (r.node_id != 0)
                begin
                    present = 1'b0;
                    for (int j = 0; j < rep_cnt[ns][pid]; j++)
                        if (rep_list[ns][pid][j] == r.node_id)
                            present = 1'b1;
                    if (!present)
                    begin
                        // full list: slot 0 is overwritten
                        if (rep_cnt[ns][pid] >= REPL)
                            rep_list[ns][pid][0] = r.node_id;
                        else
                        begin
                            rep_list[ns][pid][rep_cnt[ns][pid]] = r.node_id;
                            rep_cnt[ns][pid] = rep_cnt[ns][pid] + 2'd1;
                        end
                    end
                end
            end
            else if (!tbl_valid[ns])
                o.status = STAT_NONE;
            else if (r.req_type == REQ_GET_WRITE)
            begin
                o.node_result = wr_node[ns][pid];
                if (o.node_result == 0)
                    o.status = STAT_NONE;
            end
            else
            begin
                n = 32'(rep_cnt[ns][pid]);
                if (n == 0)
                    o.status = STAT_NONE;
                else
                begin
                    rr_cnt = rr_cnt + 32'd1;
                    o.node_result = rep_list[ns][pid][rr_cnt % n];
                    if (o.node_result == 0)
                        o.status = STAT_NONE;
                end
            end
        end
        return o;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // driver: bursts of items with random gaps, start held until the item is taken
    always @(posedge clk)
    begin : drive_requests
        logic      nxt_start;
        req_item_t nxt_req;
        nxt_start = start;
        nxt_req = req;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                route_expect_q.push_back(route_predict(req));
                nxt_start = 1'b0;
            end
            if (!nxt_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (req_backlog.size() > 0)
                begin
                    nxt_req = req_backlog.pop_front();
                    nxt_start = 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
        start <= nxt_start;
        req <= nxt_req;
    end

    always @(posedge clk)
    begin : check_results
        res_item_t want;
        if (rst_n && done)
        begin
            if (route_expect_q.size() == 0)
                flag_mismatch("result with no pending item, status", result.status, 0);
            else
            begin
                want = route_expect_q.pop_front();
                if (result.status !== want.status)
                    flag_mismatch("status", result.status, want.status);
                if (result.node_result !== want.node_result)
                    flag_mismatch("node_result", result.node_result, want.node_result);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("partition_replica_route_table test failed");
            $finish;
        end
    end

    task automatic queue_req(logic [2:0] rt, logic [1:0] ns, logic [11:0] pid, logic [7:0] node);
        req_item_t it;
        it.req_type = rt;
        it.namespace_index = ns;
        it.partition_id = pid;
        it.node_id = node;
        req_backlog.push_back(it);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (req_backlog.size() != 0 || start || route_expect_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(logic [PC_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        part_cnt = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // mostly hot partitions and a few nodes so lists fill, collide and get purged
    task automatic fill_random(int count);
        int          roll;
        int          sel;
        int          eff;
        logic [2:0]  rt;
        logic [11:0] pid;
        logic [7:0]  node;
        eff = active_parts();
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 999);
            if (roll < 200)
                rt = REQ_SET_WRITE;
            else if (roll < 500)
                rt = REQ_ADD_READ;
            else if (roll < 650)
                rt = REQ_GET_WRITE;
            else if (roll < 940)
                rt = REQ_GET_READ;
            else if (roll < 982)
                rt = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
            else
                rt = REQ_REMOVE;
            sel = $urandom_range(0, 9);
            if (sel <= 5)
                pid = 12'($urandom_range(0, 3));
            else if (sel == 6)
                pid = 12'(eff - 1);
            else if (sel == 7)
                pid = 12'(eff);
            else
                pid = 12'($urandom_range(0, MAXP - 1));
            sel = $urandom_range(0, 7);
            if (sel <= 5)
                node = 8'($urandom_range(1, 5));
            else if (sel == 6)
                node = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                node = 8'($urandom_range(0, 255));
            queue_req(rt, 2'($urandom_range(0, NS - 1)), pid, node);
        end
    endtask

    initial
    begin : stimulus
        logic [PC_W-1:0] cfg_plan [PHASES];
        cfg_plan = '{13'd4096, 13'd1, 13'd8191, 13'd64, 13'd0, 13'd3000, 13'd2, 13'd4096};
        for (int t = 0; t < NS; t++)
        begin
            tbl_valid[t] = 1'b0;
            for (int p = 0; p < MAXP; p++)
            begin
                wr_node[t][p] = '0;
                rep_cnt[t][p] = '0;
                for (int j = 0; j < REPL; j++)
                    rep_list[t][p][j] = '0;
            end
        end
        rr_cnt = '0;
        part_cnt = PC_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no table yet, then write node at both partition extremes
        queue_req(REQ_GET_WRITE, 2'd0, 12'd0, 8'd0);
        queue_req(REQ_GET_READ, 2'd1, 12'd5, 8'd0);
        queue_req(REQ_SET_WRITE, 2'd0, 12'd0, 8'hFF);
        queue_req(REQ_GET_WRITE, 2'd0, 12'd0, 8'd0);
        queue_req(REQ_SET_WRITE, 2'd0, 12'hFFF, 8'd1);
        queue_req(REQ_GET_WRITE, 2'd0, 12'hFFF, 8'd0);
        // zero node on add is ignored, list stays empty
        queue_req(REQ_ADD_READ, 2'd0, 12'd0, 8'd0);
        queue_req(REQ_GET_READ, 2'd0, 12'd0, 8'd0);
        // duplicate skipped, fourth node overwrites slot 0
        queue_req(REQ_ADD_READ, 2'd0, 12'd0, 8'd10);
        queue_req(REQ_ADD_READ, 2'd0, 12'd0, 8'd20);
        queue_req(REQ_ADD_READ, 2'd0, 12'd0, 8'd20);
        queue_req(REQ_ADD_READ, 2'd0, 12'd0, 8'd30);
        queue_req(REQ_ADD_READ, 2'd0, 12'd0, 8'd40);
        queue_req(REQ_GET_READ, 2'd0, 12'd0, 8'd0);
        queue_req(REQ_GET_READ, 2'd0, 12'd0, 8'd0);
        queue_req(REQ_GET_READ, 2'd0, 12'd0, 8'd0);
        // set with node 0 clears the write node
        queue_req(REQ_SET_WRITE, 2'd0, 12'd0, 8'd0);
        queue_req(REQ_GET_WRITE, 2'd0, 12'd0, 8'd0);
        queue_req(REQ_REMOVE, 2'd3, 12'hFFF, 8'd0);
        queue_req(REQ_REMOVE, 2'd0, 12'd0, 8'd20);
        queue_req(REQ_GET_READ, 2'd0, 12'd0, 8'd0);
        queue_req(REQ_UNUSED_LO, 2'd0, 12'd0, 8'd1);
        queue_req(REQ_UNUSED_MID, 2'd1, 12'd1, 8'd2);
        queue_req(REQ_UNUSED_HI, 2'd3, 12'hFFF, 8'hFF);
        queue_req(REQ_ADD_READ, 2'd3, 12'hFFF, 8'hFF);
        wait_idle();

        // single partition: anything above 0 is out of range
        write_count(13'd1);
        queue_req(REQ_SET_WRITE, 2'd2, 12'd1, 8'd7);
        queue_req(REQ_GET_WRITE, 2'd2, 12'd0, 8'd0);
        queue_req(REQ_SET_WRITE, 2'd2, 12'd0, 8'd7);
        queue_req(REQ_GET_WRITE, 2'd2, 12'd0, 8'd0);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_count(cfg_plan[ph]);
            fill_random(PHASE_ITEMS);
            wait_idle();
        end

        if (mismatches == 0)
            $display("partition_replica_route_table test passed");
        else
            $display("partition_replica_route_table test failed");
        $finish;
    end

endmodule

// File: files.f
rtl/prrt_pkg.sv
rtl/prrt_ram.sv
rtl/prrt_entry_update.sv
rtl/partition_replica_route_table.sv
tb/tb_partition_replica_route_table.sv
